### hdl/stereo_peak_hold_meter_ballistics_top_assert.svh
// Assertion macros for the stereo peak-hold meter ballistics block.
`ifndef STEREO_PEAK_HOLD_METER_BALLISTICS_TOP_ASSERT_SVH
`define STEREO_PEAK_HOLD_METER_BALLISTICS_TOP_ASSERT_SVH

// Same-cycle implication, checked on rising clock edges outside reset.
`define SPHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on rising clock edges outside reset.
`define SPHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sphm_pkg.sv
// Shared types, constants and per-channel update function for the meter.
package sphm_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned HOLD_W   = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FLOOR  = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_LEVEL_DECAY = 16'd62259;
    localparam logic [SAMPLE_W-1:0] RST_PEAK_DECAY  = 16'd64880;
    localparam logic [HOLD_W-1:0]   RST_HOLD_TICKS  = 8'd30;
    localparam logic [SAMPLE_W-1:0] RST_ZERO_FLOOR  = 16'd66;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level_decay;
        logic [SAMPLE_W-1:0] peak_decay;
        logic [HOLD_W-1:0]   hold_ticks;
        logic [SAMPLE_W-1:0] zero_floor;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] peak;
        logic [HOLD_W-1:0]   hold;
    } t_chan;

    // Scale by a Q0.16 multiplier, truncate, and drop to zero under the floor.
    function automatic logic [SAMPLE_W-1:0] fade(
        input logic [SAMPLE_W-1:0] v,
        input logic [SAMPLE_W-1:0] mult,
        input logic [SAMPLE_W-1:0] floor_lvl
    );
        logic [2*SAMPLE_W-1:0] prod;
        logic [SAMPLE_W-1:0]   r;
        prod = (2*SAMPLE_W)'(v) * (2*SAMPLE_W)'(mult);
        r    = prod[2*SAMPLE_W-1:SAMPLE_W];
        if (r < floor_lvl) begin
            r = '0;
        end
        return r;
    endfunction

    // One meter tick for one channel.
    function automatic t_chan chan_tick(
        input t_chan               c,
        input logic [SAMPLE_W-1:0] s,
        input t_cfg                cfg
    );
        t_chan n;
        n = c;
        if (s > c.level) begin
            n.level = s;
        end else begin
            n.level = fade(c.level, cfg.level_decay, cfg.zero_floor);
        end
        if (s > c.peak) begin
            n.peak = s;
            n.hold = cfg.hold_ticks;
        end else if (c.hold != '0) begin
            n.hold = c.hold - HOLD_W'(1);
        end else begin
            n.peak = fade(c.peak, cfg.peak_decay, cfg.zero_floor);
        end
        return n;
    endfunction

endpackage

### hdl/sphm_if.sv
// Valid/ready channel interfaces for meter samples and meter results.
interface sphm_in_if
    import sphm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sphm_out_if
    import sphm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] left_shown;
    logic [SAMPLE_W-1:0] right_shown;
    logic [SAMPLE_W-1:0] left_peak_out;
    logic [SAMPLE_W-1:0] right_peak_out;
    logic                left_holding;
    logic                right_holding;

    modport source (
        output valid, output left_shown, output right_shown,
        output left_peak_out, output right_peak_out,
        output left_holding, output right_holding,
        input  ready
    );
    modport sink (
        input  valid, input left_shown, input right_shown,
        input  left_peak_out, input right_peak_out,
        input  left_holding, input right_holding,
        output ready
    );
endinterface

### hdl/stereo_peak_hold_meter_ballistics_top.sv
// Stereo peak-hold meter ballistics: top level with config port and tick pipeline.
//
// Each transfer on i_in is one meter tick carrying the latest left and right
// levels (unsigned Q0.16). Per channel the block keeps a displayed level with
// instant attack and exponential release, and a peak that is captured on a
// rise, held for hold_ticks ticks, then released with its own rate; released
// values below zero_floor snap to zero. Every tick yields exactly one transfer
// on o_out with both levels, both peaks and the two hold flags. Throughput is
// one tick per clock while o_out accepts results; a tick passes through the
// input register, then the result register, before its result is valid. The
// rate is set by the combinational state update: per channel two 16x16
// multiplies, two floor compares and a hold counter between the input
// register and the result/state registers. Configuration uses an APB-style
// port, registers at byte address 4*i: 0 level_decay, 1 peak_decay,
// 2 hold_ticks, 3 zero_floor; write them only while no tick is in flight.
// Reset clears all meter state and restores the register defaults.
`include "stereo_peak_hold_meter_ballistics_top_assert.svh"

module stereo_peak_hold_meter_ballistics_top
    import sphm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sphm_in_if.sink               i_in,
    sphm_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    t_cfg r_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    // Input stage
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_left_sample;
    logic [SAMPLE_W-1:0] r_right_sample;

    // Meter state and result stage
    t_chan r_chan_l, r_chan_r;
    t_chan n_chan_l, n_chan_r;
    logic  r_out_valid;
    t_chan r_res_l, r_res_r;

    logic advance;   // result register can take a new tick
    logic tick;      // input stage moves into the result register

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Write one register per completed access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_decay <= RST_LEVEL_DECAY;
            r_cfg.peak_decay  <= RST_PEAK_DECAY;
            r_cfg.hold_ticks  <= RST_HOLD_TICKS;
            r_cfg.zero_floor  <= RST_ZERO_FLOOR;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LEVEL_DECAY: r_cfg.level_decay <= pwdata[SAMPLE_W-1:0];
                REG_PEAK_DECAY:  r_cfg.peak_decay  <= pwdata[SAMPLE_W-1:0];
                REG_HOLD_TICKS:  r_cfg.hold_ticks  <= pwdata[HOLD_W-1:0];
                REG_ZERO_FLOOR:  r_cfg.zero_floor  <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb begin
        case (cfg_idx)
            REG_LEVEL_DECAY: prdata = CFG_DATA_W'(r_cfg.level_decay);
            REG_PEAK_DECAY:  prdata = CFG_DATA_W'(r_cfg.peak_decay);
            REG_HOLD_TICKS:  prdata = CFG_DATA_W'(r_cfg.hold_ticks);
            REG_ZERO_FLOOR:  prdata = CFG_DATA_W'(r_cfg.zero_floor);
            default:         prdata = '0;
        endcase
    end

    // Handshake: the result register is empty or is being taken, so the
    // input stage may advance and a new sample may land behind it.
    assign advance    = !r_out_valid || o_out.ready;
    assign tick       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // Capture the sample pair on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_left_sample  <= i_in.left_sample;
            r_right_sample <= i_in.right_sample;
        end
    end

    // Per-channel ballistics: attack, release, hold countdown, floor.
    always_comb begin
        n_chan_l = chan_tick(r_chan_l, r_left_sample, r_cfg);
        n_chan_r = chan_tick(r_chan_r, r_right_sample, r_cfg);
    end

    // Advance the meter state once per tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_l <= '0;
            r_chan_r <= '0;
        end else if (tick) begin
            r_chan_l <= n_chan_l;
            r_chan_r <= n_chan_r;
        end
    end

    // Result register: hold until taken, load on each tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_res_l <= n_chan_l;
            r_res_r <= n_chan_r;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.left_shown     = r_res_l.level;
    assign o_out.right_shown    = r_res_r.level;
    assign o_out.left_peak_out  = r_res_l.peak;
    assign o_out.right_peak_out = r_res_r.peak;
    assign o_out.left_holding   = (r_res_l.hold != '0);
    assign o_out.right_holding  = (r_res_r.hold != '0);

    // A held peak was captured by a rise, so it cannot be zero.
    `SPHM_ASSERT_NOW(a_hold_l_nonzero, i_clk, i_rst_n, r_chan_l.hold != '0,
        r_chan_l.peak != '0, "left peak is zero while held")
    `SPHM_ASSERT_NOW(a_hold_r_nonzero, i_clk, i_rst_n, r_chan_r.hold != '0,
        r_chan_r.peak != '0, "right peak is zero while held")
    // A tick entering the result stage must show up as a valid result.
    `SPHM_ASSERT_NEXT(a_tick_to_out, i_clk, i_rst_n, tick,
        r_out_valid, "tick lost between input and result stage")
    // State moves only on a tick.
    `SPHM_ASSERT_NEXT(a_state_stable, i_clk, i_rst_n, !tick,
        $stable(r_chan_l) && $stable(r_chan_r), "meter state changed without a tick")

endmodule
